// File: design/mrg_pkg.sv
// Shared types, constants and codes for the multiway sorted run merge block.
package mrg_pkg;

    // Store geometry
    localparam int MAX_RUNS  = 8;
    localparam int RUN_DEPTH = 256;
    localparam int RUN_W     = $clog2(MAX_RUNS);
    localparam int ADDR_W    = $clog2(RUN_DEPTH);
    localparam int PTR_W     = $clog2(RUN_DEPTH + 1);
    localparam int CNT_W     = $clog2(MAX_RUNS + 1);
    localparam int MEM_DEPTH = MAX_RUNS * RUN_DEPTH;
    localparam int MEM_AW    = RUN_W + ADDR_W;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Item kinds
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic do_load;
        logic do_clear;
        logic scan_step;
        logic emit;
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

// File: design/mrg_ctrl.sv
// Controller state machine that sequences load, clear and pop transfers.
module mrg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic [1:0]        i_op,
    input  mrg_pkg::t_ctrl_sts i_sts,
    output logic              o_s_tready,
    output mrg_pkg::t_ctrl_cmd o_cmd
);

    mrg_pkg::t_state r_state;
    mrg_pkg::t_state n_state;
    logic            accept;

    assign accept = i_s_tvalid && (r_state == mrg_pkg::ST_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mrg_pkg::ST_IDLE: begin
                if (accept) begin
                    case (mrg_pkg::t_op'(i_op))
                        mrg_pkg::OP_LOAD:  n_state = mrg_pkg::ST_LOAD;
                        mrg_pkg::OP_POP:   n_state = mrg_pkg::ST_SCAN;
                        mrg_pkg::OP_CLEAR: n_state = mrg_pkg::ST_CLEAR;
                        default:           n_state = mrg_pkg::ST_IDLE;
                    endcase
                end
            end
            mrg_pkg::ST_LOAD:  n_state = mrg_pkg::ST_IDLE;
            mrg_pkg::ST_CLEAR: n_state = mrg_pkg::ST_IDLE;
            mrg_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = mrg_pkg::ST_EMIT;
                end
            end
            mrg_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = mrg_pkg::ST_IDLE;
                end
            end
            default: n_state = mrg_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            mrg_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = accept;
            end
            mrg_pkg::ST_LOAD:  o_cmd.do_load  = 1'b1;
            mrg_pkg::ST_CLEAR: o_cmd.do_clear = 1'b1;
            mrg_pkg::ST_SCAN:  o_cmd.scan_step = !i_sts.scan_done;
            mrg_pkg::ST_EMIT:  o_cmd.emit     = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: design/mrg_datapath.sv
// Datapath: run store, fill counts, read pointers, head scan and output register.
module mrg_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mrg_pkg::t_ctrl_cmd              i_cmd,
    output mrg_pkg::t_ctrl_sts              o_sts,
    input  logic [mrg_pkg::IDX_W-1:0]       i_run_index,
    input  logic [mrg_pkg::DATA_W-1:0]      i_value,
    input  logic                            i_cfg_we,
    input  logic [mrg_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [mrg_pkg::DATA_W-1:0]      o_merged_value,
    output logic [mrg_pkg::IDX_W-1:0]       o_source_run,
    output logic                            o_all_empty
);

    // Run store, one row of RUN_DEPTH words per run
    logic [mrg_pkg::DATA_W-1:0] r_mem [mrg_pkg::MEM_DEPTH];

    logic [mrg_pkg::PTR_W-1:0]  r_fill [mrg_pkg::MAX_RUNS];
    logic [mrg_pkg::PTR_W-1:0]  r_rptr [mrg_pkg::MAX_RUNS];
    logic [mrg_pkg::CFG_W-1:0]  r_cfg_runs;

    // Captured item
    logic [mrg_pkg::IDX_W-1:0]  r_in_run;
    logic [mrg_pkg::DATA_W-1:0] r_in_value;

    // Scan state
    logic [mrg_pkg::CNT_W-1:0]  r_scan_idx;
    logic                       r_rd_valid;
    logic [mrg_pkg::RUN_W-1:0]  r_rd_run;
    logic [mrg_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_found;
    logic [mrg_pkg::RUN_W-1:0]  r_best_run;
    logic [mrg_pkg::DATA_W-1:0] r_best;

    // Output register
    logic                       r_out_valid;
    logic [mrg_pkg::DATA_W-1:0] r_out_value;
    logic [mrg_pkg::IDX_W-1:0]  r_out_run;
    logic                       r_out_empty;

    logic [mrg_pkg::CNT_W-1:0]  limit;
    logic [mrg_pkg::RUN_W-1:0]  scan_run;
    logic [mrg_pkg::RUN_W-1:0]  load_run;
    logic                       head_ok;
    logic                       load_ok;
    logic                       better;

    // Saturate the run count at the store size
    assign limit = (32'(r_cfg_runs) > 32'(mrg_pkg::MAX_RUNS))
                 ? mrg_pkg::CNT_W'(mrg_pkg::MAX_RUNS)
                 : mrg_pkg::CNT_W'(r_cfg_runs);

    assign scan_run = r_scan_idx[mrg_pkg::RUN_W-1:0];
    assign load_run = r_in_run[mrg_pkg::RUN_W-1:0];
    assign head_ok  = r_rptr[scan_run] < r_fill[scan_run];
    assign load_ok  = (32'(r_in_run) < 32'(mrg_pkg::MAX_RUNS))
                   && (r_fill[load_run] < mrg_pkg::PTR_W'(mrg_pkg::RUN_DEPTH));
    assign better   = r_rd_valid && (!r_found || ($signed(r_rd_data) < $signed(r_best)));

    assign o_sts.scan_done = (r_scan_idx == limit);
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_runs <= mrg_pkg::CFG_W'(mrg_pkg::MAX_RUNS);
        end else if (i_cfg_we) begin
            r_cfg_runs <= i_cfg_wdata;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_run   <= i_run_index;
            r_in_value <= i_value;
        end
    end

    // Store write and head read
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load && load_ok) begin
            r_mem[{load_run, r_fill[load_run][mrg_pkg::ADDR_W-1:0]}] <= r_in_value;
        end
        r_rd_data <= r_mem[{scan_run, r_rptr[scan_run][mrg_pkg::ADDR_W-1:0]}];
        r_rd_run  <= scan_run;
    end

    // Fill counts and read pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.do_clear) begin
            for (int i = 0; i < mrg_pkg::MAX_RUNS; i++) begin
                r_fill[i] <= '0;
                r_rptr[i] <= '0;
            end
        end else begin
            if (i_cmd.do_load && load_ok) begin
                r_fill[load_run] <= r_fill[load_run] + 1'b1;
            end
            if (i_cmd.emit && r_found) begin
                r_rptr[r_best_run] <= r_rptr[r_best_run] + 1'b1;
            end
        end
    end

    // Walk the run heads, compare in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
        end else if (i_cmd.capture) begin
            r_scan_idx <= '0;
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_step && head_ok;
            if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (better) begin
                r_found <= 1'b1;
            end
        end
    end

    // Keep the least head seen so far
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_best     <= '0;
            r_best_run <= '0;
        end else if (better) begin
            r_best     <= r_rd_data;
            r_best_run <= r_rd_run;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= r_found ? r_best : '0;
            r_out_run   <= r_found ? mrg_pkg::IDX_W'(r_best_run) : '0;
            r_out_empty <= !r_found;
        end
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_source_run   = r_out_run;
    assign o_all_empty    = r_out_empty;

endmodule

// File: design/multiway_sorted_run_merge.sv
// Top level of the multiway sorted run merge block.
//
// Input channel (i_s_*): one item per transfer. tuser carries the kind: load
// appends tdata's value to the run given in tdata, pop asks for the least
// head element of the runs in use, clear empties every run. Output channel
// (o_m_*): one result for each pop, with the value and its source run in
// tdata and an empty flag in tuser (value and run read zero when set).
// i_cfg_we/i_cfg_wdata set the number of runs a pop looks at (reset 8).
//
// Timing: a load or clear holds ready low for one cycle. A pop walks the run
// heads one per cycle through the store's single read port (eight at most),
// and ready returns once its result is in the output register.
// Reset empties all runs and the output register; the store itself is not
// cleared. If the receiver stalls, the result holds in the output register
// and a following load or clear is still taken; the next pop waits at its
// last step until the held result is taken.
module multiway_sorted_run_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [mrg_pkg::S_TDATA_W-1:0]    i_s_tdata,  // run_index[2:0], value[34:3]
    input  logic [mrg_pkg::OP_W-1:0]         i_s_tuser,  // op[1:0]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [mrg_pkg::M_TDATA_W-1:0]    o_m_tdata,  // merged_value[31:0], source_run[34:32]
    output logic [0:0]                       o_m_tuser,  // all_empty[0]
    input  logic                             i_cfg_we,
    input  logic [mrg_pkg::CFG_W-1:0]        i_cfg_wdata
);

    mrg_pkg::t_ctrl_cmd          cmd;
    mrg_pkg::t_ctrl_sts          sts;
    logic [mrg_pkg::DATA_W-1:0]  merged_value;
    logic [mrg_pkg::IDX_W-1:0]   source_run;
    logic                        all_empty;

    mrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    mrg_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_run_index    (i_s_tdata[mrg_pkg::IDX_W-1:0]),
        .i_value        (i_s_tdata[mrg_pkg::IDX_W +: mrg_pkg::DATA_W]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_merged_value (merged_value),
        .o_source_run   (source_run),
        .o_all_empty    (all_empty)
    );

    // Pack the result, pad to whole bytes
    assign o_m_tdata = {{(mrg_pkg::M_TDATA_W - mrg_pkg::DATA_W - mrg_pkg::IDX_W){1'b0}},
                        source_run, merged_value};
    assign o_m_tuser = all_empty;

endmodule

// File: design/mrg_checker.sv
// Port-level checker for the multiway sorted run merge block, with its bind.
module mrg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [mrg_pkg::OP_W-1:0]      i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [mrg_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [0:0]                    o_m_tuser
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // Empty result carries zero value and run
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("empty result with nonzero data");

    // Padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[mrg_pkg::M_TDATA_W-1:mrg_pkg::DATA_W+mrg_pkg::IDX_W] == '0)
        else $error("padding bits set");

    // A real item keeps the input closed for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != mrg_pkg::OP_NONE) |=> !o_s_tready)
        else $error("input ready straight after an accepted item");

endmodule

bind multiway_sorted_run_merge mrg_checker u_mrg_checker (.*);

// File: tb/tb_top.sv
// Testbench for the multiway sorted run merge block against a merge predictor.
`timescale 1ns / 1ps

module tb_top;
    import mrg_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  run;
        logic              empty;
    } t_merge_out;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;  // run_index[2:0], value[34:3]
    logic [OP_W-1:0]      i_s_tuser;  // op[1:0]
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;  // merged_value[31:0], source_run[34:32]
    logic [0:0]           o_m_tuser;  // all_empty[0]
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;

    // Predictor copy of the run stores, pointers and run count
    logic [DATA_W-1:0] run_mem [MAX_RUNS][RUN_DEPTH];
    int unsigned       fill_cnt [MAX_RUNS];
    int unsigned       read_ptr [MAX_RUNS];
    logic [CFG_W-1:0]  run_count;
    t_merge_out        pending_merges [$];

    // Ascending value generation per run
    longint            run_tail [MAX_RUNS];
    bit                run_started [MAX_RUNS];

    // Traffic shaping
    bit                tx_gaps;
    bit                rx_stalls;
    int unsigned       burst_left;
    int unsigned       hold_len;
    int unsigned       items_sent;
    int unsigned       mismatch_count;
    int unsigned       results_seen;
    int unsigned       idle_cycles;

    multiway_sorted_run_merge dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Apply one accepted item to the predictor and queue any merge result
    function automatic void advance_merge_state(input t_op op, input logic [IDX_W-1:0] run,
                                                input logic [DATA_W-1:0] val);
        t_merge_out        res;
        logic [DATA_W-1:0] head;
        int unsigned       lim;
        bit                found;
        res   = '0;
        found = 1'b0;
        case (op)
            OP_LOAD: begin
                if (fill_cnt[run] < RUN_DEPTH) begin
                    run_mem[run][fill_cnt[run]] = val;
                    fill_cnt[run]++;
                end
            end
            OP_CLEAR: begin
                for (int r = 0; r < MAX_RUNS; r++) begin
                    fill_cnt[r] = 0;
                    read_ptr[r] = 0;
                end
            end
            OP_POP: begin
                lim = (run_count > MAX_RUNS) ? MAX_RUNS : run_count;
                for (int r = 0; r < lim; r++) begin
                    if (read_ptr[r] < fill_cnt[r]) begin
                        head = run_mem[r][read_ptr[r]];
                        if (!found || $signed(head) < $signed(res.value)) begin
                            found     = 1'b1;
                            res.value = head;
                            res.run   = r[IDX_W-1:0];
                        end
                    end
                end
                if (found) read_ptr[res.run]++;
                else res.empty = 1'b1;
                pending_merges.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Next value of an ascending run; narrow values make ties across runs likely
    function automatic logic [DATA_W-1:0] next_sorted(input int unsigned r, input bit narrow);
        longint v;
        if (!run_started[r]) begin
            if (narrow) v = longint'($urandom_range(0, 8)) - 4;
            else if ($urandom_range(0, 15) == 0) v = -64'sd2147483648;
            else v = longint'(int'($urandom));
        end else if (narrow) begin
            v = run_tail[r] + longint'($urandom_range(0, 2));
        end else if ($urandom_range(0, 1) == 0) begin
            v = run_tail[r] + longint'($urandom_range(0, 3));
        end else begin
            v = run_tail[r] + longint'($urandom_range(0, 32'h3fff_ffff));
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        run_started[r] = 1'b1;
        run_tail[r]    = v;
        return v[DATA_W-1:0];
    endfunction

    // Offer one item, wait for its transfer, then predict
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] run,
                             input logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 10);
            end
            burst_left--;
        end
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W - DATA_W - IDX_W){1'b0}}, val, run};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        advance_merge_state(op, run, val);
        items_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic drain_block();
        i_s_tvalid <= 1'b0;
        while (pending_merges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_run_count(input logic [CFG_W-1:0] count);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        run_count   = count;
    endtask

    task automatic clear_runs();
        send_item(OP_CLEAR, '0, '0);
        for (int r = 0; r < MAX_RUNS; r++) run_started[r] = 1'b0;
    endtask

    // Clear, fill runs with ascending values, pop them all plus one more
    task automatic merge_batch(input bit narrow);
        int unsigned n, pops, r;
        n    = $urandom_range(2, 24);
        pops = 0;
        clear_runs();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, MAX_RUNS - 1);
            send_item(OP_LOAD, r[IDX_W-1:0], next_sorted(r, narrow));
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_POP, IDX_W'($urandom), $urandom);
                pops++;
            end
        end
        while (pops < n + 1) begin
            send_item(OP_POP, IDX_W'($urandom), $urandom);
            pops++;
        end
    endtask

    // Random ops, unsorted values, stray pops and clears, unused code
    task automatic noise_batch();
        repeat ($urandom_range(5, 15))
            send_item(t_op'($urandom_range(0, 3)), IDX_W'($urandom), $urandom);
    endtask

    task automatic test_extremes();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        // Empty pop straight after reset
        send_item(OP_POP, '0, '0);
        // Extreme values, tie on the most positive value goes to the lower run
        send_item(OP_LOAD, 3'd0, 32'h7fff_ffff);
        send_item(OP_LOAD, 3'd3, 32'hffff_ffff);
        send_item(OP_LOAD, 3'd3, 32'h0000_0000);
        send_item(OP_LOAD, 3'd7, 32'h8000_0000);
        send_item(OP_LOAD, 3'd5, 32'h7fff_ffff);
        send_item(OP_NONE, 3'd7, 32'hffff_ffff);
        repeat (6) send_item(OP_POP, 3'd7, 32'hffff_ffff);
        // Unsorted run: the scan still takes the least head
        send_item(OP_LOAD, 3'd1, 32'd5);
        send_item(OP_LOAD, 3'd1, 32'd2);
        send_item(OP_LOAD, 3'd2, 32'd3);
        repeat (4) send_item(OP_POP, '0, '0);
        // Clear discards loaded elements
        send_item(OP_LOAD, 3'd6, 32'd9);
        send_item(OP_LOAD, 3'd4, 32'd1);
        clear_runs();
        send_item(OP_POP, '0, '0);
    endtask

    task automatic test_run_count_limits();
        // No run scanned
        write_run_count(4'd0);
        clear_runs();
        send_item(OP_LOAD, 3'd0, 32'd10);
        send_item(OP_LOAD, 3'd1, 32'hffff_ffec);
        send_item(OP_POP, '0, '0);
        // Only run 0 scanned; run 1 stays unseen
        write_run_count(4'd1);
        send_item(OP_POP, '0, '0);
        send_item(OP_POP, '0, '0);
        // Count above the run total saturates
        write_run_count(4'd15);
        send_item(OP_POP, '0, '0);
        send_item(OP_POP, '0, '0);
        write_run_count(4'd8);
    endtask

    task automatic test_full_run();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        clear_runs();
        // Two loads beyond the depth are dropped and leave the oldest entries intact
        for (int i = 0; i < RUN_DEPTH + 2; i++)
            send_item(OP_LOAD, 3'd4, 32'hffff_fc00 + i);
        repeat (4) send_item(OP_POP, '0, '0);
        drain_block();
    endtask

    task automatic test_output_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        clear_runs();
        for (int i = 0; i < 8; i++) send_item(OP_LOAD, i[IDX_W-1:0], next_sorted(i, 1'b0));
        // Hold the receiver off while pops and loads keep coming
        hold_len = HOLD_CYCLES;
        send_item(OP_POP, '0, '0);
        send_item(OP_LOAD, 3'd2, next_sorted(2, 1'b0));
        send_item(OP_LOAD, 3'd6, next_sorted(6, 1'b0));
        repeat (4) send_item(OP_POP, '0, '0);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_POP, '0, '0);
        drain_block();
    endtask

    task automatic test_random_merges();
        int unsigned first, pick;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) write_run_count(4'd0);
            else if (pick == 1) write_run_count(CFG_W'($urandom_range(9, 15)));
            else if (pick < 4) write_run_count(4'd8);
            else if (pick == 4) write_run_count(4'd1);
            else write_run_count(CFG_W'($urandom_range(1, 8)));
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) merge_batch(1'b0);
                else if (pick < 16) merge_batch(1'b1);
                else noise_batch();
            end
        end
    endtask

    // Receiver: random ready pattern, steady stretches and a long hold-off
    initial begin : receiver
        int unsigned span;
        i_m_tready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_len != 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (!rx_stalls) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 8);
                i_m_tready <= 1'b1;
                repeat (span) @(posedge i_clk);
                span = $urandom_range(0, 6);
                if (span != 0) begin
                    i_m_tready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_merge_out want, got;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            got.value = o_m_tdata[DATA_W-1:0];
            got.run   = o_m_tdata[DATA_W+IDX_W-1:DATA_W];
            got.empty = o_m_tuser[0];
            if (pending_merges.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h run %0d empty %b",
                             got.value, got.run, got.empty);
            end else begin
                want = pending_merges.pop_front();
                if (got.value !== want.value || got.run !== want.run ||
                    got.empty !== want.empty) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected value %h run %0d empty %b, ",
                                  "got value %h run %0d empty %b"},
                                 results_seen, want.value, want.run, want.empty,
                                 got.value, got.run, got.empty);
                end
            end
            results_seen++;
        end
    end

    // End the run if no transfer happens for too long
    always @(posedge i_clk) begin : stall_watch
        if ((i_s_tvalid && o_s_tready) === 1'b1 || (o_m_tvalid && i_m_tready) === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : main_seq
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_LOAD;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        tx_gaps        = 1'b0;
        rx_stalls      = 1'b0;
        burst_left     = 0;
        hold_len       = 0;
        items_sent     = 0;
        mismatch_count = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        run_count      = 4'd8;
        for (int r = 0; r < MAX_RUNS; r++) begin
            fill_cnt[r]    = 0;
            read_ptr[r]    = 0;
            run_tail[r]    = 0;
            run_started[r] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_run_count_limits();
        test_full_run();
        test_output_backpressure();
        test_random_merges();

        drain_block();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_merges.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
